/* rtl/tlsu_pkg.sv */
// tlsu_pkg: shared types and codes for the thumb load/store unit
`default_nettype none

package tlsu_pkg;

    localparam int unsigned IN_DATA_W  = 56;
    localparam int unsigned IN_USER_W  = 2;
    localparam int unsigned OUT_DATA_W = 112;

    typedef enum logic [1:0] {
        CMD_EXEC  = 2'd0,
        CMD_DATA  = 2'd1,
        CMD_SETUP = 2'd2,
        CMD_RSVD  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        KIND_WORD  = 3'd0,
        KIND_BYTE  = 3'd1,
        KIND_SBYTE = 3'd2,
        KIND_HALF  = 3'd3,
        KIND_SHALF = 3'd4
    } t_kind;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_INSTR  = 2'd1;
    localparam logic [1:0] ST_UNEXP_DATA = 2'd2;

    localparam logic [3:0] REG_SP = 4'd13;
    localparam logic [3:0] REG_PC = 4'd15;

    localparam logic [31:0] MASK_BYTE     = 32'h0000_00FF;
    localparam logic [31:0] MASK_HALF     = 32'h0000_FFFF;
    localparam logic [31:0] PC_ALIGN_MASK = ~32'd2;

    // first member sits in the highest bits
    typedef struct packed {
        logic [3:0]  reg_sel;
        logic [31:0] data_word;
        logic [15:0] instr_word;
    } t_item;

    // first member sits in the highest bits
    typedef struct packed {
        logic [3:0]  pad;
        logic [1:0]  status;
        logic [31:0] written_value;
        logic [3:0]  written_index;
        logic        reg_written;
        logic        fetch_sequential;
        logic [31:0] store_data;
        logic [1:0]  mem_size;
        logic [31:0] mem_address;
        logic        mem_write;
        logic        mem_valid;
    } t_result;

endpackage

`default_nettype wire

/* rtl/thumb_load_store_unit_top.sv */
// thumb_load_store_unit_top: thumb load/store execution with register file
//
//  channel | direction | tdata                                  | tuser
//  s_axis  | in        | instr_word, data_word, reg_sel         | cmd
//  m_axis  | out       | mem_valid .. status (one beat per in)  | -
//
// one beat per cycle sustained while m_axis_tready is high; a beat passes the input register,
// then decode/address add/load shaping into the result register
// registers and pending load state update when a beat moves into the result register
// synchronous active-low reset clears the register file, sp, pc and pending load
// a stalled result holds the result register; the input register still takes one beat
`default_nettype none

module thumb_load_store_unit_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // instr_word[15:0], data_word[47:16], reg_sel[51:48], zero pad
    input  wire logic [tlsu_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // cmd[1:0]
    input  wire logic [tlsu_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // mem_valid[0], mem_write[1], mem_address[33:2], mem_size[35:34],
    // store_data[67:36], fetch_sequential[68], reg_written[69],
    // written_index[73:70], written_value[105:74], status[107:106], zero pad
    output logic [tlsu_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
    import tlsu_pkg::*;

    logic        r_in_valid;
    t_cmd        r_cmd;
    logic [15:0] r_instr;
    logic [31:0] r_data;
    logic [3:0]  r_sel;

    logic        r_out_valid;
    t_result     r_out;
    t_result     n_out;

    logic [31:0] r_low [8];
    logic [31:0] r_sp;
    logic [31:0] r_pc;
    logic        r_pend;
    logic [2:0]  r_pdest;
    t_kind       r_pkind;
    logic [1:0]  r_plow;

    logic [31:0] n_low [8];
    logic [31:0] n_sp;
    logic [31:0] n_pc;
    logic        n_pend;
    logic [2:0]  n_pdest;
    t_kind       n_pkind;
    logic [1:0]  n_plow;

    logic        w_adv;
    logic        w_take;
    t_item       w_item;

    assign w_item        = t_item'(s_axis_tdata[51:0]);
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign w_take        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    function automatic logic [31:0] shape_load(logic [31:0] w, t_kind kind, logic [1:0] low);
        logic [7:0]  b;
        logic [15:0] h;
        logic [31:0] rot;
        begin
            unique case (low)
                2'd0: begin b = w[7:0];   rot = w; end
                2'd1: begin b = w[15:8];  rot = {w[7:0], w[31:8]}; end
                2'd2: begin b = w[23:16]; rot = {w[15:0], w[31:16]}; end
                2'd3: begin b = w[31:24]; rot = {w[23:0], w[31:24]}; end
            endcase
            h = low[1] ? w[31:16] : w[15:0];
            unique case (kind)
                KIND_BYTE:  shape_load = {24'd0, b};
                KIND_SBYTE: shape_load = {{24{b[7]}}, b};
                KIND_HALF:  shape_load = low[0] ? {h[7:0], 16'd0, h[15:8]} : {16'd0, h};
                KIND_SHALF: shape_load = low[0] ? {{24{b[7]}}, b} : {{16{h[15]}}, h};
                default:    shape_load = rot;
            endcase
        end
    endfunction

    always_comb begin
        logic [2:0]  rd;
        logic [2:0]  rb;
        logic [2:0]  ro;
        logic [4:0]  off5;
        logic [1:0]  op;
        logic        ok;
        logic        load;
        t_kind       kind;
        logic [31:0] addr;
        logic [1:0]  size;
        logic [31:0] v;
        logic [31:0] wval;

        n_out   = '0;
        n_low   = r_low;
        n_sp    = r_sp;
        n_pc    = r_pc;
        n_pend  = r_pend;
        n_pdest = r_pdest;
        n_pkind = r_pkind;
        n_plow  = r_plow;

        rd   = r_instr[2:0];
        rb   = r_instr[5:3];
        ro   = r_instr[8:6];
        off5 = r_instr[10:6];
        op   = r_instr[11:10];
        ok   = 1'b1;
        load = 1'b0;
        kind = KIND_WORD;
        addr = '0;
        size = SIZE_BYTE;
        v    = '0;
        wval = shape_load(r_data, r_pkind, r_plow);

        unique case (r_cmd)
            CMD_EXEC: begin
                priority if (r_pend) begin
                    ok = 1'b0;
                end else if (r_instr[15:11] == 5'b01001) begin
                    rd   = r_instr[10:8];
                    addr = (r_pc & PC_ALIGN_MASK) + {22'd0, r_instr[7:0], 2'b00};
                    load = 1'b1;
                    size = SIZE_WORD;
                end else if (r_instr[15:12] == 4'b0101 && !r_instr[9]) begin
                    addr = r_low[rb] + r_low[ro];
                    load = op[1];
                    size = op[0] ? SIZE_BYTE : SIZE_WORD;
                    kind = op[0] ? KIND_BYTE : KIND_WORD;
                end else if (r_instr[15:12] == 4'b0101) begin
                    addr = r_low[rb] + r_low[ro];
                    load = (op != 2'd0);
                    unique case (op)
                        2'd1:    begin size = SIZE_BYTE; kind = KIND_SBYTE; end
                        2'd2:    begin size = SIZE_HALF; kind = KIND_HALF; end
                        2'd3:    begin size = SIZE_HALF; kind = KIND_SHALF; end
                        default: begin size = SIZE_HALF; kind = KIND_WORD; end
                    endcase
                end else if (r_instr[15:13] == 3'b011) begin
                    load = r_instr[11];
                    addr = r_low[rb] + (r_instr[12] ? {27'd0, off5} : {25'd0, off5, 2'b00});
                    size = r_instr[12] ? SIZE_BYTE : SIZE_WORD;
                    kind = r_instr[12] ? KIND_BYTE : KIND_WORD;
                end else if (r_instr[15:12] == 4'b1000) begin
                    load = r_instr[11];
                    addr = r_low[rb] + {26'd0, off5, 1'b0};
                    size = SIZE_HALF;
                    kind = KIND_HALF;
                end else if (r_instr[15:12] == 4'b1001) begin
                    load = r_instr[11];
                    rd   = r_instr[10:8];
                    addr = r_sp + {22'd0, r_instr[7:0], 2'b00};
                    size = SIZE_WORD;
                end else begin
                    ok = 1'b0;
                end

                if (!ok) begin
                    n_out.status = ST_BAD_INSTR;
                end else begin
                    n_out.mem_valid   = 1'b1;
                    n_out.mem_address = addr;
                    n_out.mem_size    = size;
                    n_pc              = r_pc + 32'd2;
                    if (load) begin
                        n_out.fetch_sequential = 1'b1;
                        n_pend  = 1'b1;
                        n_pdest = rd;
                        n_pkind = kind;
                        n_plow  = addr[1:0];
                    end else begin
                        v = r_low[rd];
                        n_out.mem_write  = 1'b1;
                        n_out.store_data = (size == SIZE_BYTE) ? (v & MASK_BYTE) :
                                           (size == SIZE_HALF) ? (v & MASK_HALF) : v;
                    end
                end
            end
            CMD_DATA: begin
                if (r_pend) begin
                    n_low[r_pdest]      = wval;
                    n_pend              = 1'b0;
                    n_out.reg_written   = 1'b1;
                    n_out.written_index = {1'b0, r_pdest};
                    n_out.written_value = wval;
                end else begin
                    n_out.status = ST_UNEXP_DATA;
                end
            end
            CMD_SETUP: begin
                priority if (!r_sel[3]) begin
                    n_low[r_sel[2:0]] = r_data;
                    n_out.reg_written = 1'b1;
                end else if (r_sel == REG_SP) begin
                    n_sp              = r_data;
                    n_out.reg_written = 1'b1;
                end else if (r_sel == REG_PC) begin
                    n_pc              = r_data;
                    n_out.reg_written = 1'b1;
                end else begin
                    n_out.reg_written = 1'b0;
                end
                if (n_out.reg_written) begin
                    n_out.written_index = r_sel;
                    n_out.written_value = r_data;
                end
            end
            default: begin
                n_out.status = ST_BAD_INSTR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
        if (w_take) begin
            r_cmd   <= t_cmd'(s_axis_tuser);
            r_instr <= w_item.instr_word;
            r_data  <= w_item.data_word;
            r_sel   <= w_item.reg_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_low[i] <= '0;
            end
            r_sp    <= '0;
            r_pc    <= '0;
            r_pend  <= 1'b0;
            r_pdest <= '0;
            r_pkind <= KIND_WORD;
            r_plow  <= '0;
        end else if (w_adv) begin
            r_low   <= n_low;
            r_sp    <= n_sp;
            r_pc    <= n_pc;
            r_pend  <= n_pend;
            r_pdest <= n_pdest;
            r_pkind <= n_pkind;
            r_plow  <= n_plow;
        end
    end

    a_req_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && n_out.mem_valid |-> n_out.status == ST_OK)
        else $error("memory request with nonzero status");

    a_load_sets_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && n_out.mem_valid && !n_out.mem_write |=> r_pend)
        else $error("load request did not leave a pending load");

    a_pc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && n_out.mem_valid |=> r_pc == $past(r_pc) + 32'd2)
        else $error("pc did not advance by two on a request");

    a_no_req_when_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_pend && r_cmd == CMD_EXEC |-> !n_out.mem_valid)
        else $error("request issued while a load is pending");

endmodule

`default_nettype wire
